// File: rtl/pidfan_pkg.sv
package pidfan_pkg;

   localparam int INTEGRAL_WIDTH = 40;

   localparam int TEMP_W     = 8;
   localparam int MILLI_W    = 18;
   localparam int FRAC_W     = 10;
   localparam int ERR_W      = 20;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int GAIN_W     = 16;
   localparam int SPEED_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int P_PROD_W       = ERR_W + GAIN_W;
   localparam int D_PROD_W       = DIFF_W + GAIN_W;
   localparam int I_PROD_W       = INTEGRAL_WIDTH + GAIN_W;
   localparam int TERM_LIMIT_LOG2 = 50;
   localparam int TERM_W         = TERM_LIMIT_LOG2 + 2;
   localparam int I_EXT_W        = (I_PROD_W > TERM_W) ? I_PROD_W : TERM_W;
   localparam int SUM_W          = TERM_W + 2;

   localparam int SPEED_MAX   = 99;
   localparam int ONE_SPEED   = 256000;
   localparam int SAT_SUM     = SPEED_MAX * ONE_SPEED;
   localparam int SCALE_SHIFT = 11;
   localparam int QUOT_W      = 14;
   localparam int RECIP       = 16778;
   localparam int RECIP_W     = 15;
   localparam int RECIP_SHIFT = 21;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD_INT  = 3'd0,
      CSR_THRESHOLD_FRAC = 3'd1,
      CSR_GAIN_P         = 3'd2,
      CSR_GAIN_I         = 3'd3,
      CSR_GAIN_D         = 3'd4,
      CSR_DEAD_ZONE      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]          err;
      logic signed [DIFF_W-1:0]         diff;
      logic signed [INTEGRAL_WIDTH-1:0] integ;
   } err_terms_type;

   // The digit part is a text fraction: one digit means tenths, two mean
   // hundredths and three mean thousandths.
   function automatic logic [MILLI_W-1:0] to_milli(input logic [TEMP_W-1:0] ip,
                                                   input logic [TEMP_W-1:0] fp);
      logic [FRAC_W-1:0] f;
      if (fp < TEMP_W'(10)) begin
         f = FRAC_W'(fp) * FRAC_W'(100);
      end else if (fp < TEMP_W'(100)) begin
         f = FRAC_W'(fp) * FRAC_W'(10);
      end else begin
         f = FRAC_W'(fp);
      end
      return MILLI_W'(ip) * MILLI_W'(1000) + MILLI_W'(f);
   endfunction

endpackage

// File: rtl/pidfan_error.sv
module pidfan_error (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  logic [pidfan_pkg::TEMP_W-1:0]          temp_int,
   input  logic [pidfan_pkg::TEMP_W-1:0]          temp_frac,
   input  logic [pidfan_pkg::TEMP_W-1:0]          threshold_int,
   input  logic [pidfan_pkg::TEMP_W-1:0]          threshold_frac,
   output pidfan_pkg::err_terms_type              terms
);

   localparam int IW = pidfan_pkg::INTEGRAL_WIDTH;
   localparam int EW = pidfan_pkg::ERR_W;

   logic [pidfan_pkg::MILLI_W-1:0]   meas;
   logic [pidfan_pkg::MILLI_W-1:0]   targ;
   logic signed [EW-1:0]             err_in;
   logic signed [pidfan_pkg::DIFF_W-1:0] diff_in;
   logic signed [IW:0]               acc_sum;
   logic signed [IW-1:0]             integ_in;
   logic signed [IW-1:0]             integ_ff;
   logic signed [EW-1:0]             prev_err_ff;
   pidfan_pkg::err_terms_type        terms_in;
   pidfan_pkg::err_terms_type        terms_ff;

   always_comb begin
      meas    = pidfan_pkg::to_milli(temp_int, temp_frac);
      targ    = pidfan_pkg::to_milli(threshold_int, threshold_frac);
      err_in  = EW'(meas) - EW'(targ);
      diff_in = pidfan_pkg::DIFF_W'(err_in) - pidfan_pkg::DIFF_W'(prev_err_ff);
      acc_sum = (IW + 1)'(integ_ff) + (IW + 1)'(err_in);
      // Saturate when the two top bits of the widened sum disagree.
      if (acc_sum[IW] != acc_sum[IW-1]) begin
         integ_in = acc_sum[IW] ? {1'b1, {(IW - 1){1'b0}}} : {1'b0, {(IW - 1){1'b1}}};
      end else begin
         integ_in = acc_sum[IW-1:0];
      end
      terms_in.err   = err_in;
      terms_in.diff  = diff_in;
      terms_in.integ = integ_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         prev_err_ff <= '0;
      end else if (load) begin
         integ_ff    <= integ_in;
         prev_err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         terms_ff <= terms_in;
      end
   end

   assign terms = terms_ff;

endmodule

// File: rtl/pid_fan_speed_controller_unit.sv
// Fan speed PID controller. Each request carries a temperature as an integer part
// and a decimal-digit part read as text after the point (5 is .5, 50 is .50, 123
// is .123). The block forms the error against the programmed threshold, keeps a
// saturating integral and the previous error, weights the three terms with signed
// Q8.8 gains and returns a speed clamped to 0..99, set to 0 below the dead zone.
// The pipeline has five register stages and accepts a new request every cycle
// while req_stall is low; the integral and previous-error update is done in a
// single stage so back-to-back samples chain correctly. A stalled result holds the
// last stage only, and the earlier stages keep filling until every stage is occupied.
// The user must write the registers only while idle; the block does not enforce it.
module pid_fan_speed_controller_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [pidfan_pkg::TEMP_W-1:0]        req_temp_int,
   input  logic [pidfan_pkg::TEMP_W-1:0]        req_temp_frac,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pidfan_pkg::SPEED_W-1:0]       rsp_speed,
   input  logic                                 csr_write,
   input  logic [pidfan_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pidfan_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int GW  = pidfan_pkg::GAIN_W;
   localparam int XW  = pidfan_pkg::I_EXT_W;
   localparam int SW  = pidfan_pkg::SUM_W;
   localparam int QW  = pidfan_pkg::QUOT_W;
   localparam int MW  = pidfan_pkg::QUOT_W + pidfan_pkg::RECIP_W;
   localparam logic signed [XW-1:0] TERM_HI = XW'(1) << pidfan_pkg::TERM_LIMIT_LOG2;
   localparam logic signed [XW-1:0] TERM_LO = -TERM_HI;
   localparam logic signed [SW-1:0] SAT_SUM = SW'(pidfan_pkg::SAT_SUM);

   logic [pidfan_pkg::TEMP_W-1:0]  threshold_int_ff;
   logic [pidfan_pkg::TEMP_W-1:0]  threshold_frac_ff;
   logic signed [GW-1:0]           gain_p_ff;
   logic signed [GW-1:0]           gain_i_ff;
   logic signed [GW-1:0]           gain_d_ff;
   logic [pidfan_pkg::SPEED_W-1:0] dead_zone_ff;

   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic go0, go1, go2, go3, go4;

   logic [pidfan_pkg::TEMP_W-1:0]  temp_int_ff;
   logic [pidfan_pkg::TEMP_W-1:0]  temp_frac_ff;
   pidfan_pkg::err_terms_type      terms;

   logic signed [pidfan_pkg::ERR_W-1:0]          s1_err;
   logic signed [pidfan_pkg::DIFF_W-1:0]         s1_diff;
   logic signed [pidfan_pkg::INTEGRAL_WIDTH-1:0] s1_integ;
   logic signed [pidfan_pkg::P_PROD_W-1:0]       p_prod_in, p_prod_ff;
   logic signed [pidfan_pkg::D_PROD_W-1:0]       d_prod_in, d_prod_ff;
   logic signed [pidfan_pkg::I_PROD_W-1:0]       i_prod_in, i_prod_ff;

   logic signed [XW-1:0]                  i_ext;
   logic signed [pidfan_pkg::TERM_W-1:0]  i_term;
   logic signed [SW-1:0]                  sum;
   logic                                  sat_in, sat_ff;
   logic [QW-1:0]                         quot_in, quot_ff;

   logic [MW-1:0]                         recip_prod;
   logic [pidfan_pkg::SPEED_W-1:0]        speed_raw;
   logic [pidfan_pkg::SPEED_W-1:0]        speed_in, speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_int_ff  <= '0;
         threshold_frac_ff <= '0;
         gain_p_ff         <= GW'(5120);
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         dead_zone_ff      <= pidfan_pkg::SPEED_W'(5);
      end else if (csr_write) begin
         case (csr_index)
            pidfan_pkg::CSR_THRESHOLD_INT:  threshold_int_ff  <= csr_data[pidfan_pkg::TEMP_W-1:0];
            pidfan_pkg::CSR_THRESHOLD_FRAC: threshold_frac_ff <= csr_data[pidfan_pkg::TEMP_W-1:0];
            pidfan_pkg::CSR_GAIN_P:         gain_p_ff         <= csr_data[GW-1:0];
            pidfan_pkg::CSR_GAIN_I:         gain_i_ff         <= csr_data[GW-1:0];
            pidfan_pkg::CSR_GAIN_D:         gain_d_ff         <= csr_data[GW-1:0];
            pidfan_pkg::CSR_DEAD_ZONE:      dead_zone_ff      <= csr_data[pidfan_pkg::SPEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A stage loads when it is empty or its contents move on in the same cycle.
   assign go4       = !v4_ff || !rsp_stall;
   assign go3       = !v3_ff || go4;
   assign go2       = !v2_ff || go3;
   assign go1       = !v1_ff || go2;
   assign go0       = !v0_ff || go1;
   assign req_stall = !go0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (go0) v0_ff <= req_valid;
         if (go1) v1_ff <= v0_ff;
         if (go2) v2_ff <= v1_ff;
         if (go3) v3_ff <= v2_ff;
         if (go4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go0 && req_valid) begin
         temp_int_ff  <= req_temp_int;
         temp_frac_ff <= req_temp_frac;
      end
   end

   pidfan_error u_error (
      .clock          (clock),
      .reset          (reset),
      .load           (go1 && v0_ff),
      .temp_int       (temp_int_ff),
      .temp_frac      (temp_frac_ff),
      .threshold_int  (threshold_int_ff),
      .threshold_frac (threshold_frac_ff),
      .terms          (terms)
   );

   always_comb begin
      s1_err    = terms.err;
      s1_diff   = terms.diff;
      s1_integ  = terms.integ;
      p_prod_in = pidfan_pkg::P_PROD_W'(s1_err) * pidfan_pkg::P_PROD_W'(gain_p_ff);
      d_prod_in = pidfan_pkg::D_PROD_W'(s1_diff) * pidfan_pkg::D_PROD_W'(gain_d_ff);
      i_prod_in = pidfan_pkg::I_PROD_W'(s1_integ) * pidfan_pkg::I_PROD_W'(gain_i_ff);
   end

   always_ff @(posedge clock) begin
      if (go2 && v1_ff) begin
         p_prod_ff <= p_prod_in;
         d_prod_ff <= d_prod_in;
         i_prod_ff <= i_prod_in;
      end
   end

   always_comb begin
      i_ext = XW'(i_prod_ff);
      if (i_ext > TERM_HI) begin
         i_term = pidfan_pkg::TERM_W'(TERM_HI);
      end else if (i_ext < TERM_LO) begin
         i_term = pidfan_pkg::TERM_W'(TERM_LO);
      end else begin
         i_term = pidfan_pkg::TERM_W'(i_ext);
      end
      sum    = SW'(p_prod_ff) + SW'(d_prod_ff) + SW'(i_term);
      sat_in = !sum[SW-1] && (sum >= SAT_SUM);
      if (sum[SW-1] || sat_in) begin
         quot_in = '0;
      end else begin
         quot_in = sum[pidfan_pkg::SCALE_SHIFT+QW-1:pidfan_pkg::SCALE_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (go3 && v2_ff) begin
         sat_ff  <= sat_in;
         quot_ff <= quot_in;
      end
   end

   // The quotient by 125 is a reciprocal multiply, exact over the clamped range.
   always_comb begin
      recip_prod = MW'(quot_ff) * MW'(pidfan_pkg::RECIP);
      if (sat_ff) begin
         speed_raw = pidfan_pkg::SPEED_W'(pidfan_pkg::SPEED_MAX);
      end else begin
         speed_raw = recip_prod[pidfan_pkg::RECIP_SHIFT+pidfan_pkg::SPEED_W-1:
                                pidfan_pkg::RECIP_SHIFT];
      end
      speed_in = (speed_raw < dead_zone_ff) ? '0 : speed_raw;
   end

   always_ff @(posedge clock) begin
      if (go4 && v3_ff) begin
         speed_ff <= speed_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_speed = speed_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed <= pidfan_pkg::SPEED_W'(pidfan_pkg::SPEED_MAX)))
      else $error("Speed above the clamp limit.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_speed != '0)) |-> (rsp_speed >= dead_zone_ff))
      else $error("Nonzero speed below the dead zone.");

   assert property (@(posedge clock) disable iff (reset)
      (v0_ff && v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall) |-> req_stall)
      else $error("Request accepted while the pipeline is full and stalled.");

endmodule
